@@ design/vn_pkg.sv @@
`default_nettype none
package vn_pkg;

    localparam int IN_W      = 16;
    localparam int N_COMP    = 4;
    localparam int SQ_W      = 32;
    localparam int SUM_W     = 33;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int SQ_STAGES = 32;
    localparam int GUARD     = 15;
    localparam int CFG_W     = 3;

    localparam logic [CFG_W-1:0] COUNT_FOUR  = 3'd4;
    localparam logic [CFG_W-1:0] COUNT_RESET = 3'd3;
    localparam logic [IN_W-1:0]  OUT_MAX     = 16'd32767;

    typedef logic [IN_W-1:0] comp_t;

    // per-request side information carried alongside the arithmetic
    typedef struct packed {
        logic [N_COMP-1:0][IN_W-1:0] mag;
        logic [N_COMP-1:0]           neg;
        logic                        zero;
        logic                        four;
    } side_t;

endpackage
`default_nettype wire

@@ design/vn_sqrt.sv @@
`default_nettype none
module vn_sqrt (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [vn_pkg::RAD_W-1:0]  rad,
    output logic      [vn_pkg::ROOT_W-1:0] root
);
    import vn_pkg::*;

    logic [RAD_W-1:0] n_reg    [0:SQ_STAGES-1];
    logic [RAD_W-1:0] rt_reg   [0:SQ_STAGES-1];
    logic [RAD_W-1:0] n_next   [0:SQ_STAGES-1];
    logic [RAD_W-1:0] rt_next  [0:SQ_STAGES-1];

    // one result bit per stage, bit walks down two places each time
    always_comb begin
        logic [RAD_W-1:0] n_in;
        logic [RAD_W-1:0] rt_in;
        logic [RAD_W-1:0] bit_k;
        logic [RAD_W-1:0] trial;
        for (int k = 0; k < SQ_STAGES; k++) begin
            n_in  = (k == 0) ? rad : n_reg[(k == 0) ? 0 : k - 1];
            rt_in = (k == 0) ? '0 : rt_reg[(k == 0) ? 0 : k - 1];
            bit_k = RAD_W'(1) << (RAD_W - 2 - 2 * k);
            trial = rt_in + bit_k;
            if (n_in >= trial) begin
                n_next[k]  = n_in - trial;
                rt_next[k] = (rt_in >> 1) + bit_k;
            end else begin
                n_next[k]  = n_in;
                rt_next[k] = rt_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                n_reg[k]  <= n_next[k];
                rt_reg[k] <= rt_next[k];
            end
        end
    end

    assign root = rt_reg[SQ_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

@@ design/vn_div.sv @@
`default_nettype none
module vn_div #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [vn_pkg::IN_W-1:0]   mag,
    input  wire logic [vn_pkg::ROOT_W-1:0] root,
    output logic      [FRAC_BITS:0]        quot
);
    import vn_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 33;
    localparam int VW = ROOT_W + 1;
    localparam int RW = ROOT_W + 2;

    logic [RW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [VW-1:0] dv_reg  [0:QW];

    logic [RW-1:0] rem_next [0:QW-1];
    logic [QW-1:0] q_next   [0:QW-1];
    logic [DW-1:0] dividend;

    // rounding to nearest: (2*mag*2^(F+15) + L) / (2L)
    assign dividend = (DW'(mag) << (FRAC_BITS + GUARD + 1)) + DW'(root);

    always_comb begin
        logic [RW-1:0] trial;
        for (int j = 0; j < QW; j++) begin
            trial = {rem_reg[j][RW-2:0], low_reg[j][QW-1-j]};
            if (trial >= RW'(dv_reg[j])) begin
                rem_next[j] = trial - RW'(dv_reg[j]);
                q_next[j]   = q_reg[j] | (QW'(1) << (QW - 1 - j));
            end else begin
                rem_next[j] = trial;
                q_next[j]   = q_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RW'(dividend >> QW);
            low_reg[0] <= dividend[QW-1:0];
            q_reg[0]   <= '0;
            dv_reg[0]  <= {root, 1'b0};
            for (int j = 0; j < QW; j++) begin
                rem_reg[j+1] <= rem_next[j];
                low_reg[j+1] <= low_reg[j];
                q_reg[j+1]   <= q_next[j];
                dv_reg[j+1]  <= dv_reg[j];
            end
        end
    end

    assign quot = q_reg[QW];

endmodule
`default_nettype wire

@@ design/vector_normalize.sv @@
// throughput: one request per cycle; 32 square-root stages and one divider stage per
//   quotient bit, all advancing together whenever the output register is free or taken
// reset: synchronous active-low aresetn clears every valid bit and sets component_count to 3
`default_nettype none
module vector_normalize #(
    parameter int OUTPUT_FRACTION_BITS = 14
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [63:0]                 s_tdata,   // in_x, in_y, in_z, in_w
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [63:0]                 m_tdata,   // out_x, out_y, out_z, out_w
    output logic                             m_tuser,   // was_zero
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [vn_pkg::CFG_W-1:0]    cfg_data
);
    import vn_pkg::*;

    localparam int QW = OUTPUT_FRACTION_BITS + 1;
    localparam int CW = (QW > IN_W) ? QW : IN_W;
    localparam int SD = SQ_STAGES + QW + 2;
    localparam logic [IN_W:0] LIM = (OUTPUT_FRACTION_BITS >= 15) ?
        {1'b0, OUT_MAX} : (IN_W + 1)'(1 << OUTPUT_FRACTION_BITS);

    logic                  en;
    logic [CFG_W-1:0]      count_reg;
    logic                  vld_a_reg;
    logic [SQ_W-1:0]       sq_reg [0:N_COMP-1];
    side_t                 side_a_reg;
    side_t                 side_a_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic                  vld_line_reg [0:SD-1];
    side_t                 side_line_reg [0:SD-1];
    side_t                 side_line_next;
    side_t                 side_out;
    logic [ROOT_W-1:0]     root;
    logic [QW-1:0]         quot [0:N_COMP-1];
    logic                  m_tvalid_reg;
    logic [63:0]           m_tdata_reg;
    logic [63:0]           m_tdata_next;
    logic                  m_tuser_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en && aresetn;
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    always_comb begin
        comp_t v;
        side_a_next      = '0;
        side_a_next.four = (count_reg == COUNT_FOUR);
        for (int c = 0; c < N_COMP; c++) begin
            v = s_tdata[c*IN_W +: IN_W];
            side_a_next.neg[c] = v[IN_W-1];
            side_a_next.mag[c] = v[IN_W-1] ? (~v + 1'b1) : v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_a_reg <= side_a_next;
            for (int c = 0; c < N_COMP; c++) begin
                sq_reg[c] <= (c == N_COMP - 1 && !side_a_next.four) ? '0 :
                    SQ_W'(side_a_next.mag[c]) * SQ_W'(side_a_next.mag[c]);
            end
        end
    end

    assign sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                    + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);

    always_comb begin
        side_line_next      = side_a_reg;
        side_line_next.zero = (sum_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg          <= sum_next;
            side_line_reg[0] <= side_line_next;
            for (int s = 1; s < SD; s++) begin
                side_line_reg[s] <= side_line_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            for (int s = 0; s < SD; s++) begin
                vld_line_reg[s] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg       <= s_tvalid;
            vld_line_reg[0] <= vld_a_reg;
            for (int s = 1; s < SD; s++) begin
                vld_line_reg[s] <= vld_line_reg[s-1];
            end
            m_tvalid_reg <= vld_line_reg[SD-1];
        end
    end

    vn_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (RAD_W'(sum_reg) << (2 * GUARD)),
        .root (root)
    );

    for (genvar c = 0; c < N_COMP; c++) begin : g_div
        vn_div #(
            .FRAC_BITS (OUTPUT_FRACTION_BITS)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (side_line_reg[SQ_STAGES].mag[c]),
            .root (root),
            .quot (quot[c])
        );
    end

    assign side_out = side_line_reg[SD-1];

    always_comb begin
        logic [CW-1:0]   qx;
        logic [IN_W-1:0] m;
        m_tdata_next = '0;
        for (int c = 0; c < N_COMP; c++) begin
            qx = CW'(quot[c]);
            m  = (qx > CW'(OUT_MAX)) ? OUT_MAX : qx[IN_W-1:0];
            if (!side_out.zero && (c < N_COMP - 1 || side_out.four)) begin
                m_tdata_next[c*IN_W +: IN_W] = side_out.neg[c] ? (~m + 1'b1) : m;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= side_out.zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    logic [N_COMP-1:0] in_range;
    always_comb begin
        logic signed [IN_W:0] cv;
        for (int c = 0; c < N_COMP; c++) begin
            cv          = (IN_W + 1)'($signed(m_tdata_reg[c*IN_W +: IN_W]));
            in_range[c] = (cv <= $signed(LIM)) && (cv >= -$signed(LIM));
        end
    end

    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero-length result with non-zero components");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> &in_range)
        else $error("normalized component beyond unit magnitude");

    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
    import vn_pkg::*;

    localparam int FRAC    = 14;
    localparam int LATENCY = FRAC + 37;
    localparam int LIMIT   = 2000000;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } vec_t;

    typedef struct {
        vec_t v;
        logic zero;
    } norm_t;

    class norm_scoreboard;
        norm_t pending[$];
        logic [CFG_W-1:0] count_cfg;
        int errors;

        function new();
            count_cfg = COUNT_RESET;
            errors = 0;
        endfunction

        function logic [63:0] root64(logic [63:0] n);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [15:0] scaled(logic signed [15:0] c, logic [63:0] len);
            logic [63:0] mag;
            logic [63:0] q;
            mag = (c < 0) ? 64'(-32'(c)) : 64'(c);
            q = ((mag << (FRAC + GUARD)) * 2 + len) / (len * 2);
            if (q > 64'(OUT_MAX)) q = 64'(OUT_MAX);
            if (c < 0) q = -q;
            return q[15:0];
        endfunction

        function void note_request(vec_t v);
            norm_t e;
            logic signed [15:0] c[4];
            logic [63:0] sum;
            logic [63:0] len;
            int n;
            c[0] = v.x; c[1] = v.y; c[2] = v.z; c[3] = v.w;
            n = (count_cfg == COUNT_FOUR) ? 4 : 3;
            sum = 0;
            for (int i = 0; i < n; i++) sum += 64'(32'(c[i]) * 32'(c[i]));
            e.v = '0;
            e.zero = (sum == 0);
            if (sum != 0) begin
                len = root64(sum << (2 * GUARD));
                e.v.x = scaled(c[0], len);
                e.v.y = scaled(c[1], len);
                e.v.z = scaled(c[2], len);
                if (n == 4) e.v.w = scaled(c[3], len);
            end
            pending.push_back(e);
        endfunction

        function void check_result(vec_t v, logic zero);
            norm_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h %b", v, zero);
                return;
            end
            e = pending.pop_front();
            if (v !== e.v || zero !== e.zero) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h %b, got %h %b", e.v, e.zero, v, zero);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    vec_t s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    norm_scoreboard sb = new();
    int cycles = 0;
    bit quiet = 0;
    bit hold_off = 0;

    always #5 aclk = ~aclk;

    vector_normalize #(.OUTPUT_FRACTION_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: checking and random stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 13);
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic write_count(logic [CFG_W-1:0] val);
        cfg_valid <= 1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.count_cfg = val;
    endtask

    task automatic send_vector(vec_t v);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(v);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vec_t rand_vec();
        vec_t v;
        v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = rand_comp();
        if ($urandom_range(0, 9) == 0) begin
            v.x = 0; v.y = 0; v.z = 0;
        end
        return v;
    endfunction

    initial begin
        logic [CFG_W-1:0] cfgs[6];
        cfgs = '{3'd4, 3'd0, 3'd7, 3'd4, 3'd5, 3'd4};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed requests at reset count
        send_vector('{16'h7fff, 16'h0000, 16'h0000, 16'h0000});
        send_vector('{16'h1234, 16'h0000, 16'h0000, 16'h0000});
        send_vector('{16'h5555, 16'h8000, 16'h8000, 16'h8000});
        send_vector('{16'h0000, 16'h7fff, 16'h7fff, 16'h7fff});
        send_vector('{16'h0000, 16'h0001, 16'h0000, 16'h0000});
        send_vector('{16'h0000, 16'h0000, 16'h0000, 16'hffff});
        send_vector('{16'hffff, 16'hffff, 16'hffff, 16'hffff});
        send_vector('{16'hffff, 16'h0001, 16'h0001, 16'h0001});
        drain();
        write_count(COUNT_FOUR);
        send_vector('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_vector('{16'h7fff, 16'h0000, 16'h0000, 16'h0000});
        send_vector('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_vector('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        send_vector('{16'h0001, 16'h0000, 16'h0000, 16'h0000});
        send_vector('{16'hffff, 16'h0001, 16'hffff, 16'h0001});
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 120; i++) send_vector(rand_vec());
        join
        drain();

        foreach (cfgs[k]) begin
            write_count(cfgs[k]);
            if (k == 5) quiet = 1;
            for (int i = 0; i < 150; i++) send_vector(rand_vec());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
